// File: rtl/nfrc_pkg.sv
// ----------------------------------------------------------------------------
// nfrc_pkg
// Shared types and constants of the nearest frame rate converter.
// ----------------------------------------------------------------------------
package nfrc_pkg;

    // field and counter widths
    localparam int RATE_W     = 19;
    localparam int IN_CNT_W   = 19;
    localparam int OUT_CNT_W  = 20;
    localparam int CFG_IDX_W  = 2;

    // copy limit per input frame
    localparam int MAX_COPIES = 64;
    localparam int COPY_W     = $clog2(MAX_COPIES + 1);

    // (in_count + 1) * output_rate
    localparam int PROD_W     = IN_CNT_W + 1 + RATE_W;

    // iterative divider: dividend padded to a multiple of the bits per step
    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIVD_W     = ((PROD_W + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC)
                                * DIV_BITS_PER_CYC;
    localparam int DIV_CYCLES = DIVD_W / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [RATE_W-1:0]    RATE_RESET  = 19'd48000;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = {OUT_CNT_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_RATE  = 2'd0,
        REG_OUTPUT_RATE = 2'd1
    } t_reg_idx;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture the frame of the accepted request
        logic div_start;  // launch the target division
        logic eval;       // resolve copy count and advance out_count
        logic norm;       // bump in_count and normalize both counters
        logic pop;        // one copy taken downstream
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic rates_eq;   // effective rates equal: plain pass-through
        logic div_done;   // quotient and remainder ready
        logic no_copies;  // current frame yields nothing
        logic last;       // one copy left
    } t_sts;

endpackage

// File: rtl/nearest_frame_rate_converter.sv
// Flow: an accepted request is divided (skipped at equal rates), evaluated and
//   normalized, then its copies go out one per cycle while i_out_stall is low.
// A new request is taken only once the last copy is out (or none is due).
// Reset: synchronous active low; rates return to 48000, counters clear, no copy pending.
// ----------------------------------------------------------------------------
// nearest_frame_rate_converter
// Nearest-neighbor frame rate converter: repeats or drops whole audio frames.
// ----------------------------------------------------------------------------
module nearest_frame_rate_converter #(
    parameter int FRAME_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [nfrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nfrc_pkg::RATE_W-1:0]     i_cfg_wdata,
    // input frames
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [FRAME_BITS-1:0]           i_frame_data,
    // output copies
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [FRAME_BITS-1:0]           o_out_frame,
    output logic                            o_last_copy,
    output logic                            o_overflow
);
    import nfrc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    nfrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // counters, divider and output registers
    nfrc_dp #(
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_frame_data (i_frame_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_frame  (o_out_frame),
        .o_last_copy  (o_last_copy),
        .o_overflow   (o_overflow)
    );

endmodule

// File: rtl/nfrc_div.sv
// ----------------------------------------------------------------------------
// nfrc_div
// Restoring unsigned divider, DIV_BITS_PER_CYC quotient bits per cycle.
// ----------------------------------------------------------------------------
module nfrc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nfrc_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [nfrc_pkg::RATE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [nfrc_pkg::DIVD_W-1:0]   o_quo,
    output logic [nfrc_pkg::RATE_W-1:0]   o_rem
);
    import nfrc_pkg::*;

    logic [DIVD_W-1:0]    r_quo, n_quo;
    logic [RATE_W-1:0]    r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // shift-subtract steps of one cycle
    always_comb begin
        logic [RATE_W:0] sh;
        logic            qb;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
            sh = {n_rem, n_quo[DIVD_W-1]};
            if (sh >= {1'b0, i_divisor}) begin
                sh = sh - {1'b0, i_divisor};
                qb = 1'b1;
            end else begin
                qb = 1'b0;
            end
            n_rem = sh[RATE_W-1:0];
            n_quo = {n_quo[DIVD_W-2:0], qb};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: rtl/nfrc_dp.sv
// ----------------------------------------------------------------------------
// nfrc_dp
// Datapath: rate registers, counters, target computation and copy output.
// ----------------------------------------------------------------------------
module nfrc_dp #(
    parameter int FRAME_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nfrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nfrc_pkg::RATE_W-1:0]     i_cfg_wdata,
    input  logic [FRAME_BITS-1:0]           i_frame_data,
    input  nfrc_pkg::t_cmd                  i_cmd,
    output nfrc_pkg::t_sts                  o_sts,
    output logic [FRAME_BITS-1:0]           o_out_frame,
    output logic                            o_last_copy,
    output logic                            o_overflow
);
    import nfrc_pkg::*;

    logic [RATE_W-1:0]     r_in_rate;
    logic [RATE_W-1:0]     r_out_rate;
    logic [IN_CNT_W-1:0]   r_in_count;
    logic [OUT_CNT_W-1:0]  r_out_count;
    logic [COPY_W-1:0]     r_copies;
    logic                  r_ovf;
    logic [FRAME_BITS-1:0] r_frame;

    logic [RATE_W-1:0]     eff_ir;
    logic [RATE_W-1:0]     eff_or;
    logic                  rates_eq;
    logic [IN_CNT_W:0]     ic_plus;
    logic [PROD_W-1:0]     prod;
    logic                  div_done;
    logic [DIVD_W-1:0]     div_quo;
    logic [RATE_W-1:0]     div_rem;
    logic [DIVD_W-1:0]     target;
    logic [DIVD_W:0]       diff;
    logic [COPY_W-1:0]     n_copies;
    logic                  n_ovf;
    logic [OUT_CNT_W-1:0]  oc_mid;
    logic [OUT_CNT_W-1:0]  oc_rate;

    // a zero rate counts as one
    assign eff_ir   = (r_in_rate  == '0) ? RATE_W'(1) : r_in_rate;
    assign eff_or   = (r_out_rate == '0) ? RATE_W'(1) : r_out_rate;
    assign rates_eq = (eff_ir == eff_or);
    assign oc_rate  = OUT_CNT_W'(eff_or);

    // numerator of the target: (in_count + 1) * output_rate
    assign ic_plus = {1'b0, r_in_count} + (IN_CNT_W + 1)'(1);
    assign prod    = PROD_W'(ic_plus) * PROD_W'(eff_or);

    nfrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DIVD_W'(prod)),
        .i_divisor  (eff_ir),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // ceiling of the quotient, copies due against out_count
    always_comb begin
        target   = div_quo + DIVD_W'(div_rem != '0);
        diff     = {1'b0, target} - (DIVD_W + 1)'(r_out_count);
        n_copies = '0;
        n_ovf    = 1'b0;
        oc_mid   = r_out_count;
        if (rates_eq) begin
            n_copies = COPY_W'(1);
            if (r_out_count != OUT_CNT_MAX) begin
                oc_mid = r_out_count + 1'b1;
            end
        end else if (!diff[DIVD_W] && (diff != '0)) begin
            n_ovf    = (diff > (DIVD_W + 1)'(MAX_COPIES));
            n_copies = n_ovf ? COPY_W'(MAX_COPIES) : diff[COPY_W-1:0];
            oc_mid   = (target > DIVD_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                       : target[OUT_CNT_W-1:0];
        end
    end

    // rate registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate   <= RATE_RESET;
            r_out_rate  <= RATE_RESET;
            r_in_count  <= '0;
            r_out_count <= '0;
            r_copies    <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INPUT_RATE: begin
                        if (i_cfg_wdata != r_in_rate) begin
                            r_in_rate   <= i_cfg_wdata;
                            r_in_count  <= '0;
                            r_out_count <= '0;
                        end
                    end
                    REG_OUTPUT_RATE: begin
                        r_out_rate <= i_cfg_wdata;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                r_copies    <= n_copies;
                r_ovf       <= n_ovf;
                r_out_count <= oc_mid;
            end
            // normalize once a second's worth of input has gone by
            if (i_cmd.norm) begin
                if (ic_plus >= {1'b0, eff_ir}) begin
                    r_in_count  <= IN_CNT_W'(ic_plus - {1'b0, eff_ir});
                    r_out_count <= (r_out_count >= oc_rate) ? r_out_count - oc_rate : '0;
                end else begin
                    r_in_count <= ic_plus[IN_CNT_W-1:0];
                end
            end
            if (i_cmd.pop) begin
                r_copies <= r_copies - 1'b1;
            end
        end
    end

    // frame held for all its copies
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame <= i_frame_data;
        end
    end

    assign o_sts.rates_eq  = rates_eq;
    assign o_sts.div_done  = div_done;
    assign o_sts.no_copies = (r_copies == '0);
    assign o_sts.last      = (r_copies == COPY_W'(1));

    assign o_out_frame = r_frame;
    assign o_last_copy = (r_copies == COPY_W'(1));
    assign o_overflow  = r_ovf;

    // in_count stays below the effective input rate
    a_in_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_count < eff_ir)
        else $error("in_count reached input rate");

    // copy count never exceeds the limit
    a_copy_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copies <= COPY_W'(MAX_COPIES))
        else $error("copy count above limit");

endmodule

// File: rtl/nfrc_ctrl.sv
// ----------------------------------------------------------------------------
// nfrc_ctrl
// Controller: sequences one request through divide (skipped at equal rates), evaluate, normalize and emit.
// ----------------------------------------------------------------------------
module nfrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  nfrc_pkg::t_sts  i_sts,
    output nfrc_pkg::t_cmd  o_cmd
);
    import nfrc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EVAL = 5'b00100,
        S_NORM = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.rates_eq) begin
                        n_state = S_EVAL;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = i_sts.no_copies ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // at most one of load, eval, norm and pop per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.eval, o_cmd.norm, o_cmd.pop, o_cmd.load}))
        else $error("overlapping datapath commands");

    // an accepted request closes the input until it is done
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while busy");

    // emitting only when copies remain
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_sts.no_copies)
        else $error("copy shown with none pending");

endmodule

// File: verif/nearest_frame_rate_converter_test.sv
// ----------------------------------------------------------------------------
// nearest_frame_rate_converter_test
// Self-checking bench for the nearest frame rate converter. A behavioral
// predictor tracks both rate registers and the in/out counters, queues the
// copies each accepted frame request should produce, and a monitor checks
// every copy taken downstream against them. Directed cases cover pass-through,
// repeat, drop, the copy limit, zero rates and counter normalization. Random
// phases follow, with idle gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module nearest_frame_rate_converter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nfrc_pkg::*;

    localparam int FRAME_BITS = 64;
    localparam int SETTLE     = DIV_CYCLES + 16;
    localparam int LIMIT      = 400_000;
    localparam int SHOW_MAX   = 10;

    // spare register slots: writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [RATE_W-1:0] RATE_TOP = 19'd384000;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic                  last;
        logic                  ovf;
    } copy_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [RATE_W-1:0]     i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [FRAME_BITS-1:0] i_frame_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [FRAME_BITS-1:0] o_out_frame;
    logic                  o_last_copy;
    logic                  o_overflow;

    // predictor state
    logic [RATE_W-1:0]    pred_in_rate;
    logic [RATE_W-1:0]    pred_out_rate;
    logic [IN_CNT_W-1:0]  pred_in_cnt;
    logic [OUT_CNT_W-1:0] pred_out_cnt;

    copy_t pending_copies[$];

    bit quiet = 1'b0;  // no idling on either side
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned frames_sent = 0;
    int unsigned n_copies = 0;
    int unsigned n_ovf_copies = 0;
    int unsigned n_cfg = 0;

    nearest_frame_rate_converter #(
        .FRAME_BITS (FRAME_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_data (i_frame_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_frame  (o_out_frame),
        .o_last_copy  (o_last_copy),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("nearest_frame_rate_converter_test: errors");
            $finish;
        end
    end

    // downstream stall, drawn at random with a 28 percent chance
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 28);
    end

    // copy monitor
    always @(posedge i_clk) begin : monitor
        copy_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_copies.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected copy: frame=%h last=%b ovf=%b",
                             o_out_frame, o_last_copy, o_overflow);
            end else begin
                want = pending_copies.pop_front();
                n_copies++;
                if (o_overflow)
                    n_ovf_copies++;
                if (o_out_frame !== want.frame || o_last_copy !== want.last ||
                    o_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("copy mismatch: exp frame=%h last=%b ovf=%b, got frame=%h last=%b ovf=%b",
                                 want.frame, want.last, want.ovf,
                                 o_out_frame, o_last_copy, o_overflow);
                end
            end
        end
    end

    // effective rate: zero counts as one
    function automatic longint unsigned eff_rate(input logic [RATE_W-1:0] r);
        return (r == '0) ? 64'd1 : 64'(r);
    endfunction

    // queue the copies one frame request causes and advance the counters
    function automatic void predict_copies(input logic [FRAME_BITS-1:0] frame);
        longint unsigned ir, orr, ic, oc, target, due;
        int unsigned n;
        logic ovf;
        copy_t c;
        ir = eff_rate(pred_in_rate);
        orr = eff_rate(pred_out_rate);
        ic = 64'(pred_in_cnt);
        oc = 64'(pred_out_cnt);
        n = 0;
        ovf = 1'b0;
        if (ir == orr) begin
            n = 1;
            if (oc < 64'(OUT_CNT_MAX))
                oc++;
        end else begin
            target = ((ic + 1) * orr + ir - 1) / ir;
            if (target > oc) begin
                due = target - oc;
                if (due > 64'(MAX_COPIES)) begin
                    n = MAX_COPIES;
                    ovf = 1'b1;
                end else begin
                    n = int'(due);
                end
                oc = target;
            end
            if (oc > 64'(OUT_CNT_MAX))
                oc = 64'(OUT_CNT_MAX);
        end
        for (int k = 0; k < n; k++) begin
            c.frame = frame;
            c.last = (k + 1 == n);
            c.ovf = ovf;
            pending_copies.push_back(c);
        end
        // normalize once a full second of input has gone by
        ic++;
        if (ic >= ir) begin
            ic -= ir;
            oc = (oc >= orr) ? oc - orr : 64'd0;
        end
        pred_in_cnt = ic[IN_CNT_W-1:0];
        pred_out_cnt = oc[OUT_CNT_W-1:0];
    endfunction

    function automatic logic [FRAME_BITS-1:0] rand_frame();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // send one frame request, with a random idle gap in front
    task automatic send_frame(input logic [FRAME_BITS-1:0] frame);
        int gap;
        gap = 0;
        if (!quiet)
            while (gap < 20 && $urandom_range(99) < 28)
                gap++;
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_frame_data <= frame;
        do @(posedge i_clk); while (o_in_stall);
        predict_copies(frame);
        frames_sent++;
        // request taken: withdraw it before the payload moves on
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_frame(rand_frame());
    endtask

    // drop the request line and wait for every copy, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_copies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write; only called after drain()
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == REG_INPUT_RATE) begin
            if (val != pred_in_rate) begin
                pred_in_rate = val;
                pred_in_cnt = '0;
                pred_out_cnt = '0;
            end
        end else if (idx == REG_OUTPUT_RATE) begin
            pred_out_rate = val;
        end
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] in_r, input logic [RATE_W-1:0] out_r);
        drain();
        cfg_write(REG_INPUT_RATE, in_r);
        cfg_write(REG_OUTPUT_RATE, out_r);
    endtask

    // reset rates: every frame passes once
    task automatic test_passthrough();
        send_frame('0);
        send_frame('1);
        send_frame({32'hAAAA_AAAA, 32'hAAAA_AAAA});
        send_frame({32'h5555_5555, 32'h5555_5555});
    endtask

    // repeated copies, the copy limit and its overflow flag
    task automatic test_repeat_and_limit();
        set_rates(19'd1, 19'd64);
        send_random(1);
        set_rates(19'd1, 19'd65);
        send_random(1);
        set_rates(19'd1, RATE_TOP);
        send_random(1);
        set_rates(19'd3, 19'd7);
        send_random(3);
    endtask

    // dropped frames, down to the slowest output
    task automatic test_drop();
        set_rates(RATE_TOP, 19'd1);
        send_random(3);
        set_rates(19'd7, 19'd3);
        send_random(5);
    endtask

    // zero register values behave as one
    task automatic test_zero_rates();
        set_rates(19'd0, 19'd0);
        send_random(2);
        drain();
        cfg_write(REG_OUTPUT_RATE, 19'd5);
        send_random(1);
    endtask

    // out_count below output_rate at normalization floors at zero
    task automatic test_counter_floor();
        set_rates(19'd10, 19'd2);
        send_random(5);
        drain();
        cfg_write(REG_OUTPUT_RATE, 19'd10);
        send_random(5);
    endtask

    // same input_rate keeps the counters; spare indexes are ignored
    task automatic test_config_rewrite();
        set_rates(19'd5, 19'd3);
        send_random(3);
        drain();
        cfg_write(REG_INPUT_RATE, 19'd5);
        cfg_write(REG_SPARE_A, RATE_W'($urandom));
        cfg_write(REG_SPARE_B, RATE_W'($urandom));
        send_random(6);
    endtask

    // requests and copies back to back, no idling
    task automatic test_burst();
        set_rates(19'd3, 19'd4);
        quiet = 1'b1;
        send_random(24);
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_phases(input int target_frames);
        logic [RATE_W-1:0] audio[12] = '{19'd8000, 19'd11025, 19'd16000, 19'd22050,
                                         19'd32000, 19'd44100, 19'd48000, 19'd88200,
                                         19'd96000, 19'd176400, 19'd192000, RATE_TOP};
        logic [RATE_W-1:0] in_r, out_r;
        int start, len;
        start = frames_sent;
        while (frames_sent - start < target_frames) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    in_r = RATE_W'($urandom_range(1, 16));
                    out_r = RATE_W'($urandom_range(1, 16));
                end
                5, 6: begin
                    in_r = audio[$urandom_range(11)];
                    out_r = audio[$urandom_range(11)];
                end
                7: begin
                    in_r = RATE_W'($urandom_range(1, 384000));
                    out_r = in_r;
                end
                8: begin
                    in_r = RATE_W'($urandom_range(1, 4));
                    out_r = in_r * RATE_W'($urandom_range(40, 80));
                end
                default: begin
                    in_r = RATE_W'($urandom_range(2, 383999));
                    out_r = ($urandom_range(1)) ? in_r + 1'b1 : in_r - 1'b1;
                end
            endcase
            drain();
            // sometimes keep one register, or rewrite input_rate unchanged
            if ($urandom_range(3) != 0)
                cfg_write(REG_INPUT_RATE, in_r);
            else
                cfg_write(REG_INPUT_RATE, pred_in_rate);
            if ($urandom_range(3) != 0)
                cfg_write(REG_OUTPUT_RATE, out_r);
            if ($urandom_range(7) == 0)
                cfg_write(($urandom_range(1)) ? REG_SPARE_A : REG_SPARE_B,
                          RATE_W'($urandom));
            len = $urandom_range(6, 18);
            send_random(len / 2);
            // now and then hold off until all copies are out
            if ($urandom_range(3) == 0)
                drain();
            send_random(len - len / 2);
        end
    endtask

    initial begin
        pred_in_rate = RATE_RESET;
        pred_out_rate = RATE_RESET;
        pred_in_cnt = '0;
        pred_out_cnt = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_repeat_and_limit();
        test_drop();
        test_zero_rates();
        test_counter_floor();
        test_config_rewrite();
        test_burst();
        test_random_phases(40);
        drain();

        if (pending_copies.size() != 0) begin
            $display("%0d expected copies never arrived", pending_copies.size());
            mismatches += pending_copies.size();
        end
        $display("covered %0d frame requests, %0d copies (%0d flagged overflow), %0d register writes",
                 frames_sent, n_copies, n_ovf_copies, n_cfg);
        $display("rates swept from zero to %0d, with stalls and idle gaps on both sides",
                 RATE_TOP);
        if (mismatches == 0)
            $display("nearest_frame_rate_converter_test: clean");
        else
            $display("nearest_frame_rate_converter_test: errors");
        $finish;
    end

endmodule
